// ----- design/lscs_pkg.sv -----
// Shared constants for the line-scan camera sequencer.
// No dependencies; every other design file refers to this package by scoped names.
package lscs_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 7;
  localparam int COUNT_W   = 16;

  localparam int PIXELS_DEFAULT = 128;

  localparam logic [COUNT_W-1:0] INTEGRATION_RESET = COUNT_W'(768);

  // Item kinds on the input channel.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

endpackage

// ----- design/lscs_channels.sv -----
// Handshake channel interfaces for the line-scan camera sequencer.
// Depends on lscs_pkg for the payload widths.
interface lscs_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [lscs_pkg::SAMPLE_W-1:0]  adc_sample;
  logic [lscs_pkg::INDEX_W-1:0]   read_index;

  modport source (output valid, kind, adc_sample, read_index, input ready);
  modport sink   (input valid, kind, adc_sample, read_index, output ready);
endinterface

interface lscs_out_if;
  logic                           valid;
  logic                           ready;
  logic                           cam_clock;
  logic                           cam_start;
  logic                           capturing;
  logic                           line_done;
  logic [lscs_pkg::SAMPLE_W-1:0]  read_data;

  modport source (output valid, cam_clock, cam_start, capturing, line_done, read_data,
                  input ready);
  modport sink   (input valid, cam_clock, cam_start, capturing, line_done, read_data,
                  output ready);
endinterface

// ----- design/lscs_line_store.sv -----
// Pixel line store: one write port, one read port with registered read data.
// Depends on lscs_pkg for the sample width.
module lscs_line_store #(
  parameter int PIXELS = lscs_pkg::PIXELS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [$clog2(PIXELS)-1:0]          wr_addr,
  input  logic [lscs_pkg::SAMPLE_W-1:0]      wr_data,
  input  logic                               rd_en,
  input  logic [$clog2(PIXELS)-1:0]          rd_addr,
  output logic [lscs_pkg::SAMPLE_W-1:0]      rd_data
);

  logic [lscs_pkg::SAMPLE_W-1:0] mem [PIXELS];
  logic [lscs_pkg::SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/line_scan_camera_sequencer.sv -----
// Top level of the line-scan camera sequencer: capture control and result register.
// Depends on lscs_pkg, lscs_channels (lscs_in_if, lscs_out_if) and lscs_line_store.
//
//   Channel  | Direction | Handshake          | Carries
//   ---------+-----------+--------------------+----------------------------------------
//   in_item  | in        | valid / ready      | kind, adc_sample, read_index
//   out_item | out       | valid / ready      | cam_clock, cam_start, capturing,
//            |           |                    | line_done, read_data
//   cfg_*    | in        | cfg_we, no wait    | integration_ticks (16 bit)
//
// Each item is handled at the edge that accepts it: the capture state and the result
// register update there, and the result is valid from the next cycle on. One item
// per cycle is sustained while the result side takes items; the single result register
// sets that figure. If the result is not taken, in_item.ready drops until it is.
// Reset (rst_n low, synchronous) sets the countdown and integration period to 768 and
// idles the sensor lines; the line store is not cleared and needs no clearing pass.
module line_scan_camera_sequencer #(
  parameter int PIXELS = lscs_pkg::PIXELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lscs_in_if.sink                       in_item,
  lscs_out_if.source                    out_item,
  input  logic                          cfg_we,
  input  logic [lscs_pkg::COUNT_W-1:0]  cfg_data
);

  // Address width of the line store and width of the signed phase counter, which runs
  // from -2 up to 2*PIXELS.
  localparam int AW = $clog2(PIXELS);
  localparam int PW = $clog2(2 * PIXELS + 1) + 1;

  localparam logic signed [PW-1:0] PH_START   = -PW'(2);
  localparam logic signed [PW-1:0] PH_PULSE   = -PW'(1);
  localparam logic signed [PW-1:0] PH_FIRST   = PW'(1);
  localparam logic signed [PW-1:0] PH_CLOCKED = PW'(2);
  localparam logic signed [PW-1:0] PH_END     = PW'(2 * PIXELS);

  // Capture and countdown state.
  logic [lscs_pkg::COUNT_W-1:0] integ_r;
  logic [lscs_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                         active_r, active_nxt;
  logic signed [PW-1:0]         phase_r, phase_nxt;
  logic                         clock_r, clock_nxt;
  logic                         start_r, start_nxt;
  logic                         done_c;

  // Line store ports.
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic                           rd_en;
  logic                           idx_in_range;
  logic [lscs_pkg::SAMPLE_W-1:0]  rd_data;

  // Result register.
  logic out_valid_r;
  logic out_clock_r;
  logic out_start_r;
  logic out_capt_r;
  logic out_done_r;
  logic out_rd_sel_r;

  logic accept;
  logic tick;
  logic clock_toggled;

  // The result register frees as soon as its item is taken, so a new item can enter
  // in the same cycle.
  assign in_item.ready = !out_valid_r || out_item.ready;
  assign accept        = in_item.valid && in_item.ready;
  assign tick          = accept && (in_item.kind == lscs_pkg::KIND_TICK);

  assign idx_in_range  = 32'(in_item.read_index) < 32'(PIXELS);
  assign rd_en         = accept && (in_item.kind == lscs_pkg::KIND_READ) && idx_in_range;
  assign clock_toggled = !clock_r;

  // One tick: a running capture advances first, then the integration countdown is
  // handled. An expiry arms a capture; if one is already running this changes nothing,
  // and if one ends on this tick the next one is armed right away.
  always_comb begin
    count_nxt  = count_r;
    active_nxt = active_r;
    phase_nxt  = phase_r;
    clock_nxt  = clock_r;
    start_nxt  = start_r;
    done_c     = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = '0;

    if (tick) begin
      if (active_r) begin
        if (phase_r >= PH_CLOCKED && phase_r < PH_END) begin
          // Pixels are sampled on the falling sensor clock.
          clock_nxt = clock_toggled;
          phase_nxt = phase_r + PW'(1);
          if (!clock_toggled) begin
            wr_en   = 1'b1;
            wr_addr = phase_r[AW:1];
          end
        end else if (phase_r < PH_CLOCKED) begin
          // Lead-in: start pulse rises at phase -1 and falls at phase 1, where the
          // first pixel is taken.
          clock_nxt = clock_toggled;
          phase_nxt = phase_r + PW'(1);
          if (phase_r == PH_PULSE) begin
            start_nxt = 1'b1;
          end else if (phase_r == PH_FIRST) begin
            start_nxt = 1'b0;
            wr_en     = 1'b1;
            wr_addr   = '0;
          end
        end else begin
          // End of line: park the clock low and rewind the phase.
          clock_nxt  = 1'b0;
          phase_nxt  = PH_START;
          active_nxt = 1'b0;
          done_c     = 1'b1;
        end
      end

      if (count_r <= lscs_pkg::COUNT_W'(1)) begin
        count_nxt  = integ_r;
        active_nxt = 1'b1;
      end else begin
        count_nxt = count_r - lscs_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r  <= lscs_pkg::INTEGRATION_RESET;
      count_r  <= lscs_pkg::INTEGRATION_RESET;
      active_r <= 1'b0;
      phase_r  <= PH_START;
      clock_r  <= 1'b0;
      start_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        integ_r <= cfg_data;
      end
      count_r  <= count_nxt;
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      clock_r  <= clock_nxt;
      start_r  <= start_nxt;
    end
  end

  // Result register: the valid flag is control, the rest is payload loaded on accept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_clock_r  <= clock_nxt;
      out_start_r  <= start_nxt;
      out_capt_r   <= active_nxt;
      out_done_r   <= done_c;
      out_rd_sel_r <= rd_en;
    end
  end

  lscs_line_store #(
    .PIXELS (PIXELS)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_item.adc_sample),
    .rd_en   (rd_en),
    .rd_addr (AW'(in_item.read_index)),
    .rd_data (rd_data)
  );

  assign out_item.valid     = out_valid_r;
  assign out_item.cam_clock = out_clock_r;
  assign out_item.cam_start = out_start_r;
  assign out_item.capturing = out_capt_r;
  assign out_item.line_done = out_done_r;
  assign out_item.read_data = out_rd_sel_r ? rd_data : '0;

  // The start pulse is only ever high between its rise at phase -1 and its fall at
  // phase 1, so the phase has then reached 0 or 1.
  a_start_window: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (phase_r == PW'(0) || phase_r == PH_FIRST))
    else $error("start pulse high outside its phase window");

  // With no capture running the sequencer sits at its starting phase, clock low.
  a_idle_parked: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (phase_r == PH_START && !clock_r && !start_r))
    else $error("idle sequencer not parked");

  // A countdown expiry on a tick always leaves a capture armed or running.
  a_expiry_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && count_r <= lscs_pkg::COUNT_W'(1)) |=> active_r)
    else $error("countdown expiry did not arm a capture");

  // Line done is reported only by an accepted tick that ends a running capture.
  a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
    done_c |-> (tick && active_r && phase_r == PH_END))
    else $error("line done without a completed capture");

endmodule

// ----- sim/lscs_checker.sv -----
// Scoreboard for the line-scan camera sequencer: watches both channels and the
// configuration port, predicts every result and compares it. Depends on lscs_pkg
// and on the lscs_in_if / lscs_out_if interfaces.
module lscs_checker #(
  parameter int PIXELS = lscs_pkg::PIXELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lscs_in_if                            in_mon,
  lscs_out_if                           out_mon,
  input  logic                          cfg_we,
  input  logic [lscs_pkg::COUNT_W-1:0]  cfg_data,
  output int                            errors,
  output int                            pending,
  output logic                          lines_ready
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                           cam_clock;
    logic                           cam_start;
    logic                           capturing;
    logic                           line_done;
    logic [lscs_pkg::SAMPLE_W-1:0]  read_data;
  } scan_result_t;

  // Mirror of the sequencer state.
  logic [lscs_pkg::COUNT_W-1:0]   period_ticks;
  logic [lscs_pkg::COUNT_W-1:0]   countdown;
  logic                           capture_on;
  logic signed [9:0]              phase;
  logic                           clock_level;
  logic                           start_level;
  logic [lscs_pkg::SAMPLE_W-1:0]  pixel_mem [PIXELS];

  scan_result_t expected_q[$];

  initial begin
    errors      = 0;
    pending     = 0;
    lines_ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] checker: %s got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  // Applies one accepted item to the mirrored state and returns its result.
  function automatic scan_result_t sequence_item(input logic kind,
                                                 input logic [15:0] sample,
                                                 input logic [6:0] index);
    scan_result_t r;
    r = '0;
    if (kind == lscs_pkg::KIND_TICK) begin
      // A capture running at the start of the tick advances before the countdown.
      if (capture_on) begin
        clock_level = ~clock_level;
        if (phase >= 2 && phase < 2 * PIXELS) begin
          if (!clock_level) pixel_mem[int'(phase) / 2] = sample;
          phase++;
        end else if (phase < 2) begin
          if (phase == -1) begin
            start_level = 1'b1;
          end else if (phase == 1) begin
            start_level  = 1'b0;
            pixel_mem[0] = sample;
          end
          phase++;
        end else begin
          clock_level = 1'b0;
          phase       = -2;
          capture_on  = 1'b0;
          r.line_done = 1'b1;
          lines_ready = 1'b1;
        end
      end
      if (countdown <= 1) begin
        countdown  = period_ticks;
        capture_on = 1'b1;
      end else begin
        countdown--;
      end
    end else if (int'(index) < PIXELS) begin
      r.read_data = pixel_mem[index];
    end
    r.cam_clock = clock_level;
    r.cam_start = start_level;
    r.capturing = capture_on;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    scan_result_t want;
    if (!rst_n) begin
      period_ticks = lscs_pkg::INTEGRATION_RESET;
      countdown    = lscs_pkg::INTEGRATION_RESET;
      capture_on   = 1'b0;
      phase        = -2;
      clock_level  = 1'b0;
      start_level  = 1'b0;
      lines_ready  = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we) period_ticks = cfg_data;
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected, read_data", out_mon.read_data, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.cam_clock !== want.cam_clock)
            report_mismatch("cam_clock", 16'(out_mon.cam_clock), 16'(want.cam_clock));
          if (out_mon.cam_start !== want.cam_start)
            report_mismatch("cam_start", 16'(out_mon.cam_start), 16'(want.cam_start));
          if (out_mon.capturing !== want.capturing)
            report_mismatch("capturing", 16'(out_mon.capturing), 16'(want.capturing));
          if (out_mon.line_done !== want.line_done)
            report_mismatch("line_done", 16'(out_mon.line_done), 16'(want.line_done));
          if (out_mon.read_data !== want.read_data)
            report_mismatch("read_data", out_mon.read_data, want.read_data);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(sequence_item(in_mon.kind, in_mon.adc_sample,
                                           in_mon.read_index));
      end
    end
    pending = expected_q.size();
  end

endmodule

// ----- sim/tb.sv -----
// Top of the line-scan camera sequencer testbench: clock, reset, stimulus and verdict.
// Depends on lscs_pkg, the channel interfaces, the sequencer RTL and lscs_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXELS = lscs_pkg::PIXELS_DEFAULT;

  // The receiver holds off this long once, while the sender keeps offering items,
  // so that the single result register fills and the input side has to stall.
  localparam int HOLD_CYCLES = 200;

  // Slowest correct run: roughly 1450 items, each with the longest sender gap and
  // the longest receiver stall, plus the one long hold-off and the drains. The limit
  // leaves several times that.
  localparam int CYCLE_LIMIT = 600_000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [lscs_pkg::COUNT_W-1:0] cfg_data;

  int  errors;
  int  pending;
  logic lines_ready;
  int  cycle_count = 0;

  // Both flags are written by the stimulus process only. The receiver reads them:
  // quiet turns all idling off, and hold_wanted asks for the one long hold-off.
  bit quiet       = 1'b0;
  bit hold_wanted = 1'b0;

  lscs_in_if  in_bus ();
  lscs_out_if out_bus ();

  always #5ns clk = ~clk;

  line_scan_camera_sequencer #(.PIXELS(PIXELS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_bus),
    .out_item (out_bus),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  lscs_checker #(.PIXELS(PIXELS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .pending     (pending),
    .lines_ready (lines_ready)
  );

  // Idle lengths for both sides: mostly none, often a few cycles, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Samples lean on the all-zero and all-one extremes so that both reach the line
  // store and come back on reads.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] pick_index();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'(PIXELS - 1);
      default: return 7'($urandom);
    endcase
  endfunction

  // Timeout guard. Counting starts at time zero, so reset is included.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("line_scan_camera_sequencer verification failed");
      $finish;
    end
  end

  // Receiver. Ready changes only at falling edges. The long hold-off is counted
  // here in its own loop so that the sender keeps pushing while it runs.
  initial begin : receiver
    int stall_left;
    bit hold_served;
    stall_left  = 0;
    hold_served = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_served) begin
        hold_served = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (quiet) begin
        stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Offers one item, entered and left at a falling edge. Valid stays high from one
  // item to the next when there is no gap, so back-to-back items are never split.
  task automatic send_item(input logic kind, input logic [15:0] sample,
                           input logic [6:0] index);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.kind       <= kind;
    in_bus.adc_sample <= sample;
    in_bus.read_index <= index;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every predicted result has been taken, which
  // leaves the block idle: each item causes exactly one result.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Reads are issued only once a full line has been captured, so no read ever
  // touches a store entry that was never written.
  task automatic run_phase(input int count, input int read_pct);
    for (int i = 0; i < count; i++) begin
      if (lines_ready && $urandom_range(0, 99) < read_pct) begin
        send_item(lscs_pkg::KIND_READ, 16'($urandom), pick_index());
      end else begin
        send_item(lscs_pkg::KIND_TICK, pick_sample(), 7'($urandom));
      end
    end
  endtask

  task automatic write_period(input logic [15:0] ticks);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= ticks;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    in_bus.valid      = 1'b0;
    in_bus.kind       = lscs_pkg::KIND_TICK;
    in_bus.adc_sample = '0;
    in_bus.read_index = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A zero period must behave like one. Written before the first expiry, it is
    // picked up by the reload that ends the 768-tick reset countdown. From then on
    // the countdown expires on every tick, so re-arming while a capture runs is
    // ignored and a new line is armed on the tick that ends one.
    write_period(16'd0);

    // Tick until the first complete line. The receiver takes its one long hold-off
    // here while items keep coming. Then read back both ends of the line, their
    // neighbors and the middle pixel.
    hold_wanted = 1'b1;
    while (!lines_ready) send_item(lscs_pkg::KIND_TICK, pick_sample(), 7'($urandom));
    send_item(lscs_pkg::KIND_READ, 16'hFFFF, 7'd0);
    send_item(lscs_pkg::KIND_READ, 16'h0000, 7'(PIXELS - 1));
    send_item(lscs_pkg::KIND_READ, 16'h0000, 7'd1);
    send_item(lscs_pkg::KIND_READ, 16'hFFFF, 7'(PIXELS - 2));
    send_item(lscs_pkg::KIND_READ, 16'h5A5A, 7'(PIXELS / 2));

    // Shortest nonzero period; it is loaded on the very next tick.
    write_period(16'd1);
    run_phase(40, 20);

    // A short random period with no idling on either side.
    write_period(16'($urandom_range(2, 40)));
    quiet = 1'b1;
    run_phase(50, 25);
    quiet = 1'b0;

    // One tick short of a full line: the expiry lands while a capture still runs.
    // Enough ticks to pass the pending reload and one whole period.
    write_period(16'd258);
    run_phase(320, 5);

    // Let the last results drain, then a few more cycles for any stray output.
    wait_drained();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("line_scan_camera_sequencer verification clean");
    end else begin
      $display("line_scan_camera_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lscs_pkg.sv
design/lscs_channels.sv
design/lscs_line_store.sv
design/line_scan_camera_sequencer.sv
sim/lscs_checker.sv
sim/tb.sv
